>>> hdl/mwcc_pkg.sv
// ----------------------------------------------------------------------------
// mwcc_pkg
// Shared types and constants of the mecanum wheel command controller.
// ----------------------------------------------------------------------------
package mwcc_pkg;

    typedef enum logic [1:0] {
        OP_VELOCITY = 2'd0,
        OP_TICK     = 2'd1,
        OP_ESTOP    = 2'd2,
        OP_ENABLE   = 2'd3
    } op_code_t;

    typedef enum logic [1:0] {
        FRAME_WHEEL  = 2'd0,
        FRAME_ENABLE = 2'd1,
        FRAME_REPLY  = 2'd2
    } frame_kind_t;

    localparam logic [2:0] RPL_ENABLED     = 3'd0;
    localparam logic [2:0] RPL_ALREADY_ON  = 3'd1;
    localparam logic [2:0] RPL_REFUSED     = 3'd2;
    localparam logic [2:0] RPL_DISABLED    = 3'd3;
    localparam logic [2:0] RPL_ALREADY_OFF = 3'd4;

    localparam logic [2:0] REG_GAIN      = 3'd0;
    localparam logic [2:0] REG_HALF_BASE = 3'd1;
    localparam logic [2:0] REG_SMOOTH    = 3'd2;
    localparam logic [2:0] REG_ACCEL     = 3'd3;
    localparam logic [2:0] REG_DECEL     = 3'd4;
    localparam logic [2:0] REG_TIMEOUT   = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;

    localparam int AXES   = 3;
    localparam int WHEELS = 4;

    // wheel i subtracts vy when bit i of NEG_Y is set, subtracts term for NEG_T
    localparam logic [WHEELS-1:0] WHEEL_NEG_Y = 4'b1001;
    localparam logic [WHEELS-1:0] WHEEL_NEG_T = 4'b0101;

    typedef struct packed {
        logic        smoothing;
        logic        stopping;
        logic [15:0] accel;
        logic [15:0] decel;
    } axis_cfg_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_DIV,
        LN_SQ,
        LN_CUBE,
        LN_POLY,
        LN_MUL,
        LN_RND
    } lane_state_t;

    typedef enum logic [1:0] {
        WL_IDLE,
        WL_MUL,
        WL_SAT
    } wheel_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EASE_GO,
        ST_EASE_WAIT,
        ST_MERGE,
        ST_TERM_MUL,
        ST_TERM_RND,
        ST_WHEEL_GO,
        ST_WHEEL_WAIT,
        ST_SEND_ENA,
        ST_SEND_WHL,
        ST_SEND_RPL
    } ctrl_state_t;

endpackage

>>> hdl/mwcc_axis_lane.sv
// ----------------------------------------------------------------------------
// mwcc_axis_lane
// One velocity axis: smoothstep easing of current toward target, with an
// iterative divider for the time fraction and registered multiplies.
// ----------------------------------------------------------------------------
module mwcc_axis_lane
    import mwcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  axis_cfg_t          cfg,
    input  logic        [31:0] dt,
    input  logic signed [31:0] cur,
    input  logic signed [31:0] tgt,
    output logic               busy,
    output logic signed [31:0] result
);

    lane_state_t        state_reg;
    logic        [16:0] rem_reg;
    logic        [15:0] quo_reg;
    logic        [3:0]  cnt_reg;
    logic        [15:0] dur_reg;
    logic        [16:0] t_reg;
    logic        [33:0] sq_reg;
    logic        [49:0] cube_reg;
    logic        [16:0] s_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] result_reg;

    logic        [32:0] abs_cur;
    logic        [32:0] abs_tgt;
    logic        [15:0] dur;
    logic        [16:0] rem_sh;
    logic               q_bit;
    logic        [50:0] poly;
    logic signed [32:0] diff;
    logic signed [51:0] rnd_sum;
    logic signed [35:0] rnd_val;
    logic signed [35:0] new_val;

    always_comb
    begin
        abs_cur = cur[31] ? -{cur[31], cur} : {cur[31], cur};
        abs_tgt = tgt[31] ? -{tgt[31], tgt} : {tgt[31], tgt};
        dur     = (cfg.stopping || (abs_tgt <= abs_cur)) ? cfg.decel : cfg.accel;
        rem_sh  = {rem_reg[15:0], 1'b0};
        q_bit   = (rem_sh >= {1'b0, dur_reg});
        poly    = (51'({sq_reg, 16'b0}) * 51'd3) - 51'({cube_reg, 1'b0});
        diff    = {tgt[31], tgt} - {cur[31], cur};
        rnd_sum = {prod_reg[50], prod_reg} + 52'sd32768 - 52'(prod_reg[50]);
        rnd_val = 36'(rnd_sum >>> 16);
        new_val = 36'(cur) + rnd_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LN_IDLE;
            cnt_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            case (state_reg)
                LN_IDLE:
                begin
                    if (start)
                    begin
                        dur_reg <= dur;
                        if (!cfg.smoothing || (dur == '0))
                        begin
                            result_reg <= tgt;
                        end
                        else if (dt >= {16'b0, dur})
                        begin
                            t_reg     <= 17'h10000;
                            state_reg <= LN_SQ;
                        end
                        else
                        begin
                            rem_reg   <= {1'b0, dt[15:0]};
                            quo_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= LN_DIV;
                        end
                    end
                end
                LN_DIV:
                begin
                    rem_reg <= q_bit ? (rem_sh - {1'b0, dur_reg}) : rem_sh;
                    quo_reg <= {quo_reg[14:0], q_bit};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        t_reg     <= {1'b0, quo_reg[14:0], q_bit};
                        state_reg <= LN_SQ;
                    end
                end
                LN_SQ:
                begin
                    sq_reg    <= 34'(t_reg) * 34'(t_reg);
                    state_reg <= LN_CUBE;
                end
                LN_CUBE:
                begin
                    cube_reg  <= 50'(sq_reg) * 50'(t_reg);
                    state_reg <= LN_POLY;
                end
                LN_POLY:
                begin
                    s_reg     <= poly[48:32];
                    state_reg <= LN_MUL;
                end
                LN_MUL:
                begin
                    prod_reg  <= 51'(diff) * 51'($signed({1'b0, s_reg}));
                    state_reg <= LN_RND;
                end
                LN_RND:
                begin
                    result_reg <= new_val[31:0];
                    state_reg  <= LN_IDLE;
                end
                default:
                begin
                    state_reg <= LN_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != LN_IDLE);
    assign result = result_reg;

endmodule

>>> hdl/mwcc_wheel_lane.sv
// ----------------------------------------------------------------------------
// mwcc_wheel_lane
// One wheel: signed body velocity sum, gain multiply, rounding and int16
// saturation.
// ----------------------------------------------------------------------------
module mwcc_wheel_lane
    import mwcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               neg_y,
    input  logic               neg_t,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [36:0] term,
    input  logic        [15:0] gain,
    output logic               busy,
    output logic signed [15:0] speed
);

    wheel_state_t       state_reg;
    logic signed [37:0] sum_reg;
    logic signed [54:0] prod_reg;
    logic signed [15:0] speed_reg;

    logic signed [37:0] vx_ext;
    logic signed [37:0] vy_ext;
    logic signed [37:0] t_ext;
    logic signed [37:0] sum;
    logic signed [55:0] rnd_sum;
    logic signed [38:0] rnd_val;
    logic signed [15:0] sat;

    always_comb
    begin
        vx_ext  = 38'(vx);
        vy_ext  = 38'(vy);
        t_ext   = 38'(term);
        sum     = vx_ext + (neg_y ? -vy_ext : vy_ext) + (neg_t ? -t_ext : t_ext);
        rnd_sum = {prod_reg[54], prod_reg} + 56'sd32768 - 56'(prod_reg[54]);
        rnd_val = 39'(rnd_sum >>> 16);
        if (rnd_val > 39'sd32767)
            sat = 16'sh7FFF;
        else if (rnd_val < -39'sd32768)
            sat = 16'sh8000;
        else
            sat = rnd_val[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WL_IDLE;
            speed_reg <= '0;
        end
        else
        begin
            case (state_reg)
                WL_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg   <= sum;
                        state_reg <= WL_MUL;
                    end
                end
                WL_MUL:
                begin
                    prod_reg  <= 55'(sum_reg) * 55'($signed({1'b0, gain}));
                    state_reg <= WL_SAT;
                end
                WL_SAT:
                begin
                    speed_reg <= sat;
                    state_reg <= WL_IDLE;
                end
                default:
                begin
                    state_reg <= WL_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != WL_IDLE);
    assign speed = speed_reg;

endmodule

>>> hdl/mecanum_wheel_command_controller.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_command_controller
// A control tick with motion runs the 16-step divider in each axis lane and
// then the wheel lanes before its result is loaded; other items skip the lanes.
// Throughput: one item at a time, the next is taken once results are loaded;
// a result held by rsp_ready stalls the input for as long.
// Reset: velocities and times zero, wheels and commands on, e-stop off,
// registers at their documented defaults.
// ----------------------------------------------------------------------------
module mecanum_wheel_command_controller
    import mwcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic        [2:0]  cfg_index,
    input  logic        [19:0] cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic        [1:0]  operation,
    input  logic        [31:0] timestamp_ms,
    input  logic signed [31:0] velocity_x,
    input  logic signed [31:0] velocity_y,
    input  logic signed [31:0] yaw_rate,
    input  logic               request_flag,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic        [1:0]  frame_kind,
    output logic signed [15:0] wheel_speed_0,
    output logic signed [15:0] wheel_speed_1,
    output logic signed [15:0] wheel_speed_2,
    output logic signed [15:0] wheel_speed_3,
    output logic               motor_disable,
    output logic        [2:0]  reply_code,
    output logic               last_result
);

    logic [15:0] gain_reg;
    logic [19:0] half_base_reg;
    logic        smooth_reg;
    logic [15:0] accel_reg;
    logic [15:0] decel_reg;
    logic [15:0] timeout_reg;
    logic [15:0] thresh_reg;

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    logic signed [31:0] cur_reg [AXES];
    logic signed [31:0] tgt_reg [AXES];
    logic        [31:0] last_smooth_reg;
    logic        [31:0] last_cmd_reg;
    logic               wheels_on_reg;
    logic               stopping_reg;
    logic               commands_on_reg;
    logic               estop_on_reg;
    logic        [31:0] dt_reg;
    logic               dis_reg;
    logic               ena_last_reg;
    logic               whl_zero_reg;
    logic        [2:0]  code_reg;
    logic signed [52:0] term_prod_reg;
    logic signed [36:0] term_reg;

    logic               rsp_valid_reg;
    logic        [1:0]  kind_reg;
    logic signed [15:0] speed_reg [WHEELS];
    logic               out_dis_reg;
    logic        [2:0]  out_code_reg;
    logic               out_last_reg;

    logic               accept;
    logic               ease_start;
    logic               wheel_start;
    logic               out_load;
    logic               out_free;
    logic [AXES-1:0]    axis_busy;
    logic [WHEELS-1:0]  wheel_busy;
    logic signed [31:0] axis_res [AXES];
    logic signed [15:0] wheel_res [WHEELS];
    axis_cfg_t          axis_cfg;
    logic [AXES-1:0]    below;
    logic [31:0]        since_cmd;
    logic [2:0]         reply;
    logic signed [53:0] term_sum;

    assign accept   = cmd_valid && cmd_ready;
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign axis_cfg.smoothing = smooth_reg;
    assign axis_cfg.stopping  = stopping_reg;
    assign axis_cfg.accel     = accel_reg;
    assign axis_cfg.decel     = decel_reg;

    genvar gi;
    generate
        for (gi = 0; gi < AXES; gi++)
        begin : g_axis
            mwcc_axis_lane u_axis (
                .clk    (clk),
                .rst_n  (rst_n),
                .start  (ease_start),
                .cfg    (axis_cfg),
                .dt     (dt_reg),
                .cur    (cur_reg[gi]),
                .tgt    (tgt_reg[gi]),
                .busy   (axis_busy[gi]),
                .result (axis_res[gi])
            );
            assign below[gi] = ((axis_res[gi][31] ? -{axis_res[gi][31], axis_res[gi]}
                                : {axis_res[gi][31], axis_res[gi]}) < {17'b0, thresh_reg});
        end
        for (gi = 0; gi < WHEELS; gi++)
        begin : g_wheel
            mwcc_wheel_lane u_wheel (
                .clk   (clk),
                .rst_n (rst_n),
                .start (wheel_start),
                .neg_y (WHEEL_NEG_Y[gi]),
                .neg_t (WHEEL_NEG_T[gi]),
                .vx    (cur_reg[0]),
                .vy    (cur_reg[1]),
                .term  (term_reg),
                .gain  (gain_reg),
                .busy  (wheel_busy[gi]),
                .speed (wheel_res[gi])
            );
        end
    endgenerate

    always_comb
    begin
        since_cmd = timestamp_ms - last_cmd_reg;
        term_sum  = {term_prod_reg[52], term_prod_reg} + 54'sd32768
                    - 54'(term_prod_reg[52]);
        if (request_flag)
        begin
            if (estop_on_reg || !wheels_on_reg)
                reply = RPL_REFUSED;
            else if (commands_on_reg)
                reply = RPL_ALREADY_ON;
            else
                reply = RPL_ENABLED;
        end
        else
        begin
            reply = commands_on_reg ? RPL_DISABLED : RPL_ALREADY_OFF;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_code_t'(operation))
                        OP_VELOCITY:
                            if (!estop_on_reg && commands_on_reg && !wheels_on_reg)
                                state_next = ST_SEND_ENA;
                        OP_TICK:
                            state_next = (estop_on_reg || !wheels_on_reg) ? ST_SEND_WHL
                                                                          : ST_EASE_GO;
                        OP_ESTOP:
                            state_next = ST_SEND_ENA;
                        OP_ENABLE:
                            state_next = ST_SEND_RPL;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EASE_GO:    state_next = ST_EASE_WAIT;
            ST_EASE_WAIT:  if (axis_busy == '0) state_next = ST_MERGE;
            ST_MERGE:      state_next = ST_TERM_MUL;
            ST_TERM_MUL:   state_next = ST_TERM_RND;
            ST_TERM_RND:   state_next = ST_WHEEL_GO;
            ST_WHEEL_GO:   state_next = ST_WHEEL_WAIT;
            ST_WHEEL_WAIT: if (wheel_busy == '0) state_next = ST_SEND_WHL;
            ST_SEND_ENA:
                if (out_free) state_next = ena_last_reg ? ST_IDLE : ST_SEND_WHL;
            ST_SEND_WHL:   if (out_free) state_next = ST_IDLE;
            ST_SEND_RPL:   if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready   = (state_reg == ST_IDLE);
        ease_start  = (state_reg == ST_EASE_GO);
        wheel_start = (state_reg == ST_WHEEL_GO);
        out_load    = out_free && ((state_reg == ST_SEND_ENA) ||
                                   (state_reg == ST_SEND_WHL) ||
                                   (state_reg == ST_SEND_RPL));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 16'd20000;
            half_base_reg <= 20'd30442;
            smooth_reg    <= 1'b1;
            accel_reg     <= 16'd300;
            decel_reg     <= 16'd300;
            timeout_reg   <= 16'd500;
            thresh_reg    <= 16'd33;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:      gain_reg      <= cfg_data[15:0];
                REG_HALF_BASE: half_base_reg <= cfg_data;
                REG_SMOOTH:    smooth_reg    <= cfg_data[0];
                REG_ACCEL:     accel_reg     <= cfg_data[15:0];
                REG_DECEL:     decel_reg     <= cfg_data[15:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                REG_THRESHOLD: thresh_reg    <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < AXES; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            last_smooth_reg <= '0;
            last_cmd_reg    <= '0;
            wheels_on_reg   <= 1'b1;
            stopping_reg    <= 1'b0;
            commands_on_reg <= 1'b1;
            estop_on_reg    <= 1'b0;
            dis_reg         <= 1'b0;
            ena_last_reg    <= 1'b0;
            whl_zero_reg    <= 1'b0;
            code_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (op_code_t'(operation))
                            OP_VELOCITY:
                            begin
                                if (!estop_on_reg && commands_on_reg)
                                begin
                                    tgt_reg[0]      <= velocity_x;
                                    tgt_reg[1]      <= velocity_y;
                                    tgt_reg[2]      <= yaw_rate;
                                    last_smooth_reg <= timestamp_ms;
                                    last_cmd_reg    <= timestamp_ms;
                                    stopping_reg    <= 1'b0;
                                    wheels_on_reg   <= 1'b1;
                                    dis_reg         <= 1'b0;
                                    ena_last_reg    <= 1'b1;
                                end
                            end
                            OP_TICK:
                            begin
                                if (estop_on_reg || !wheels_on_reg)
                                begin
                                    for (int i = 0; i < AXES; i++)
                                    begin
                                        cur_reg[i] <= '0;
                                        tgt_reg[i] <= '0;
                                    end
                                    whl_zero_reg <= 1'b1;
                                end
                                else
                                begin
                                    if ((since_cmd > {16'b0, timeout_reg}) && !stopping_reg)
                                    begin
                                        for (int i = 0; i < AXES; i++)
                                            tgt_reg[i] <= '0;
                                        stopping_reg <= 1'b1;
                                    end
                                    dt_reg          <= timestamp_ms - last_smooth_reg;
                                    last_smooth_reg <= timestamp_ms;
                                    whl_zero_reg    <= 1'b0;
                                end
                            end
                            OP_ESTOP:
                            begin
                                wheels_on_reg <= request_flag;
                                estop_on_reg  <= !request_flag;
                                for (int i = 0; i < AXES; i++)
                                begin
                                    cur_reg[i] <= '0;
                                    tgt_reg[i] <= '0;
                                end
                                dis_reg      <= !request_flag;
                                ena_last_reg <= 1'b0;
                                whl_zero_reg <= 1'b1;
                            end
                            OP_ENABLE:
                            begin
                                code_reg <= reply;
                                if (reply == RPL_ENABLED)
                                begin
                                    commands_on_reg <= 1'b1;
                                    last_cmd_reg    <= timestamp_ms;
                                end
                                if (reply == RPL_DISABLED)
                                begin
                                    commands_on_reg <= 1'b0;
                                    for (int i = 0; i < AXES; i++)
                                        tgt_reg[i] <= '0;
                                    stopping_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MERGE:
                begin
                    if (below == '1)
                    begin
                        for (int i = 0; i < AXES; i++)
                            cur_reg[i] <= '0;
                        stopping_reg <= 1'b0;
                    end
                    else
                    begin
                        for (int i = 0; i < AXES; i++)
                            cur_reg[i] <= axis_res[i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TERM_MUL)
            term_prod_reg <= 53'($signed({1'b0, half_base_reg})) * 53'(cur_reg[2]);
        if (state_reg == ST_TERM_RND)
            term_reg <= 37'(term_sum >>> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < WHEELS; i++)
                speed_reg[i] <= '0;
            out_dis_reg  <= 1'b0;
            out_code_reg <= '0;
            out_last_reg <= 1'b1;
            case (state_reg)
                ST_SEND_ENA:
                begin
                    kind_reg     <= FRAME_ENABLE;
                    out_dis_reg  <= dis_reg;
                    out_last_reg <= ena_last_reg;
                end
                ST_SEND_WHL:
                begin
                    kind_reg <= FRAME_WHEEL;
                    for (int i = 0; i < WHEELS; i++)
                        speed_reg[i] <= whl_zero_reg ? 16'sd0 : wheel_res[i];
                end
                default:
                begin
                    kind_reg     <= FRAME_REPLY;
                    out_code_reg <= code_reg;
                end
            endcase
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign frame_kind    = kind_reg;
    assign wheel_speed_0 = speed_reg[0];
    assign wheel_speed_1 = speed_reg[1];
    assign wheel_speed_2 = speed_reg[2];
    assign wheel_speed_3 = speed_reg[3];
    assign motor_disable = out_dis_reg;
    assign reply_code    = out_code_reg;
    assign last_result   = out_last_reg;

endmodule

>>> sim/mecanum_wheel_command_controller_tb.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_command_controller_tb
// Drives velocity commands, ticks, e-stop and enable service items through
// random valid/ready gaps, predicts every frame with an in-bench model of the
// easing, timeout and inverse kinematics, and compares each frame in order.
// ----------------------------------------------------------------------------
module mecanum_wheel_command_controller_tb;
    import mwcc_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        ts;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wz;
        logic               req;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] w0;
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic signed [15:0] w3;
        logic               dis;
        logic [2:0]         code;
        logic               last;
    } frame_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [19:0] cfg_data;
    logic cmd_valid;
    logic cmd_ready;
    logic [1:0] operation;
    logic [31:0] timestamp_ms;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] yaw_rate;
    logic request_flag;
    logic rsp_valid;
    logic rsp_ready;
    logic [1:0] frame_kind;
    logic signed [15:0] wheel_speed_0;
    logic signed [15:0] wheel_speed_1;
    logic signed [15:0] wheel_speed_2;
    logic signed [15:0] wheel_speed_3;
    logic motor_disable;
    logic [2:0] reply_code;
    logic last_result;

    mecanum_wheel_command_controller uut (.*);

    // predictor state
    longint unsigned gain_r, hbase_r, smooth_r, accel_r, decel_r, tmo_r, thr_r;
    longint cur_v [3];
    longint tgt_v [3];
    logic [31:0] smooth_t, cmd_t;
    bit wheels_on, stopping, cmds_on, estop_on;

    cmd_item_t pending_cmds [$];
    frame_t expected_frames [$];
    int errors;
    int idle_cycles;
    int accepted;
    bit hold_sender;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic longint round16(longint x);
        if (x >= 0)
            return (x + 32768) >>> 16;
        return -((-x + 32768) >>> 16);
    endfunction

    function automatic longint absl(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint eased(longint c, longint g, logic [31:0] dt, longint unsigned dur);
        longint unsigned t, s;
        if (dur == 0)
            return g;
        if (dt >= dur)
            t = 65536;
        else
            t = (longint'(dt) << 16) / dur;
        s = ((3 * t * t * 65536) - (2 * t * t * t)) >> 32;
        return c + round16((g - c) * longint'(s));
    endfunction

    function automatic frame_t wheel_frame(logic last);
        frame_t f;
        longint term, sum, cnt;
        logic signed [15:0] w [4];
        term = round16(longint'(hbase_r) * cur_v[2]);
        for (int i = 0; i < 4; i++)
        begin
            sum = cur_v[0] + (WHEEL_NEG_Y[i] ? -cur_v[1] : cur_v[1])
                + (WHEEL_NEG_T[i] ? -term : term);
            cnt = round16(sum * longint'(gain_r));
            if (cnt > 32767) cnt = 32767;
            if (cnt < -32768) cnt = -32768;
            w[i] = cnt[15:0];
        end
        f = '0;
        f.kind = FRAME_WHEEL;
        f.w0 = w[0]; f.w1 = w[1]; f.w2 = w[2]; f.w3 = w[3];
        f.last = last;
        return f;
    endfunction

    function automatic frame_t plain_frame(frame_kind_t k, logic d, logic [2:0] c);
        frame_t f;
        f = '0;
        f.kind = k;
        f.dis = d;
        f.code = c;
        f.last = 1'b1;
        return f;
    endfunction

    task automatic clear_motion();
        for (int i = 0; i < 3; i++)
        begin
            cur_v[i] = 0;
            tgt_v[i] = 0;
        end
    endtask

    task automatic predict_frames(cmd_item_t it);
        longint nxt [3];
        logic [31:0] dt;
        logic [31:0] since;
        logic [2:0] code;
        longint unsigned dur;
        frame_t f;
        case (it.op)
            OP_VELOCITY:
            begin
                if (!estop_on && cmds_on)
                begin
                    tgt_v[0] = it.vx; tgt_v[1] = it.vy; tgt_v[2] = it.wz;
                    smooth_t = it.ts;
                    cmd_t = it.ts;
                    stopping = 0;
                    if (!wheels_on)
                    begin
                        wheels_on = 1;
                        expected_frames.push_back(plain_frame(FRAME_ENABLE, 1'b0, RPL_ENABLED));
                    end
                end
            end
            OP_TICK:
            begin
                if (estop_on || !wheels_on)
                begin
                    clear_motion();
                    expected_frames.push_back(wheel_frame(1'b1));
                end
                else
                begin
                    since = it.ts - cmd_t;
                    if (since > tmo_r && !stopping)
                    begin
                        for (int i = 0; i < 3; i++) tgt_v[i] = 0;
                        stopping = 1;
                    end
                    dt = it.ts - smooth_t;
                    smooth_t = it.ts;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (smooth_r != 0)
                        begin
                            dur = (stopping || absl(tgt_v[i]) <= absl(cur_v[i])) ? decel_r : accel_r;
                            nxt[i] = eased(cur_v[i], tgt_v[i], dt, dur);
                        end
                        else
                            nxt[i] = tgt_v[i];
                    end
                    if (absl(nxt[0]) < thr_r && absl(nxt[1]) < thr_r && absl(nxt[2]) < thr_r)
                    begin
                        for (int i = 0; i < 3; i++) nxt[i] = 0;
                        stopping = 0;
                    end
                    for (int i = 0; i < 3; i++) cur_v[i] = nxt[i];
                    expected_frames.push_back(wheel_frame(1'b1));
                end
            end
            OP_ESTOP:
            begin
                wheels_on = it.req;
                estop_on = !it.req;
                clear_motion();
                f = plain_frame(FRAME_ENABLE, !it.req, RPL_ENABLED);
                f.last = 1'b0;
                expected_frames.push_back(f);
                expected_frames.push_back(wheel_frame(1'b1));
            end
            default:
            begin
                if (it.req)
                begin
                    if (estop_on || !wheels_on)
                        code = RPL_REFUSED;
                    else if (cmds_on)
                        code = RPL_ALREADY_ON;
                    else
                    begin
                        cmds_on = 1;
                        cmd_t = it.ts;
                        code = RPL_ENABLED;
                    end
                end
                else if (!cmds_on)
                    code = RPL_ALREADY_OFF;
                else
                begin
                    cmds_on = 0;
                    for (int i = 0; i < 3; i++) tgt_v[i] = 0;
                    stopping = 1;
                    code = RPL_DISABLED;
                end
                expected_frames.push_back(plain_frame(FRAME_REPLY, 1'b0, code));
            end
        endcase
    endtask

    // accepted_edge marks an acceptance at the last rising edge
    bit accepted_edge;
    always @(posedge clk)
        accepted_edge <= cmd_valid && cmd_ready;

    // driver
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && accepted_edge)
                cmd_valid <= 1'b0;
            else if (!cmd_valid && !hold_sender && pending_cmds.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else
                begin
                    cmd_valid <= 1'b1;
                    operation <= pending_cmds[0].op;
                    timestamp_ms <= pending_cmds[0].ts;
                    velocity_x <= pending_cmds[0].vx;
                    velocity_y <= pending_cmds[0].vy;
                    yaw_rate <= pending_cmds[0].wz;
                    request_flag <= pending_cmds[0].req;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            predict_frames(pending_cmds.pop_front());
            accepted <= accepted + 1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end
    end

    // receiver
    int recv_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (rsp_valid && rsp_ready)
        begin
            rsp_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        frame_t got, want;
        if (rsp_valid && rsp_ready)
        begin
            recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            got = {frame_kind, wheel_speed_0, wheel_speed_1, wheel_speed_2,
                   wheel_speed_3, motor_disable, reply_code, last_result};
            if (expected_frames.size() == 0)
            begin
                $display("%0t unexpected frame: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got !== want)
                    $display({"%0t mismatch: expected kind %0d w %0d %0d %0d %0d",
                              " dis %0d code %0d last %0d, actual kind %0d",
                              " w %0d %0d %0d %0d dis %0d code %0d last %0d"},
                        $time, want.kind, want.w0, want.w1, want.w2, want.w3, want.dis,
                        want.code, want.last, got.kind, got.w0, got.w1, got.w2, got.w3,
                        got.dis, got.code, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, longint unsigned val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[19:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_GAIN:      gain_r = val & 16'hFFFF;
            REG_HALF_BASE: hbase_r = val & 20'hFFFFF;
            REG_SMOOTH:    smooth_r = val & 1;
            REG_ACCEL:     accel_r = val & 16'hFFFF;
            REG_DECEL:     decel_r = val & 16'hFFFF;
            REG_TIMEOUT:   tmo_r = val & 16'hFFFF;
            REG_THRESHOLD: thr_r = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        hold_sender = 0;
        wait (pending_cmds.size() == 0 && !cmd_valid && expected_frames.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic push_cmd(op_code_t op, logic [31:0] dt, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z, logic r);
        cmd_item_t it;
        clock_ms = clock_ms + dt;
        it.op = op; it.ts = clock_ms; it.vx = x; it.vy = y; it.wz = z; it.req = r;
        pending_cmds.push_back(it);
    endtask

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh0;
            2: return $signed($urandom_range(0, 40)) - 20;
            default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        endcase
    endfunction

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 25)
                push_cmd(OP_VELOCITY, $urandom_range(0, 40), rand_vel(), rand_vel(),
                         rand_vel(), $urandom);
            else if (k < 85)
                push_cmd(OP_TICK, ($urandom_range(0, 20) == 0) ? $urandom :
                         $urandom_range(0, 120), rand_vel(), rand_vel(), rand_vel(), $urandom);
            else if (k < 92)
                push_cmd(OP_ESTOP, $urandom_range(0, 40), $urandom, $urandom, $urandom,
                         $urandom_range(0, 3) != 0);
            else
                push_cmd(OP_ENABLE, $urandom_range(0, 40), $urandom, $urandom, $urandom,
                         $urandom_range(0, 2) != 0);
        end
    endtask

    initial
    begin
        errors = 0; idle_cycles = 0; accepted = 0; hold_sender = 0;
        send_gap = 0; recv_gap = 0; accepted_edge = 0; clock_ms = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        cmd_valid = 1'b0; rsp_ready = 1'b0; operation = '0; timestamp_ms = '0;
        velocity_x = '0; velocity_y = '0; yaw_rate = '0; request_flag = 1'b0;
        gain_r = 20000; hbase_r = 30442; smooth_r = 1; accel_r = 300; decel_r = 300;
        tmo_r = 500; thr_r = 33;
        clear_motion();
        smooth_t = 0; cmd_t = 0; wheels_on = 1; stopping = 0; cmds_on = 1; estop_on = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed items with reset settings
        push_cmd(OP_VELOCITY, 5, 32'sh7FFFFFFF, 32'sh80000000, 32'sh10000, 1'b0);
        push_cmd(OP_TICK, 10, 0, 0, 0, 1'b0);
        push_cmd(OP_TICK, 400, 0, 0, 0, 1'b0);
        push_cmd(OP_VELOCITY, 1, 32'sh10000, -32'sh8000, -32'sh20000, 1'b1);
        push_cmd(OP_TICK, 150, 0, 0, 0, 1'b0);
        push_cmd(OP_TICK, 700, 0, 0, 0, 1'b0);
        push_cmd(OP_TICK, 300, 0, 0, 0, 1'b0);
        push_cmd(OP_ENABLE, 1, 0, 0, 0, 1'b1);
        push_cmd(OP_ENABLE, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ENABLE, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_VELOCITY, 1, 32'sh10000, 0, 0, 1'b0);
        push_cmd(OP_ENABLE, 1, 0, 0, 0, 1'b1);
        push_cmd(OP_ESTOP, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_TICK, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ENABLE, 1, 0, 0, 0, 1'b1);
        push_cmd(OP_VELOCITY, 1, 32'sh10000, 0, 0, 1'b0);
        push_cmd(OP_ESTOP, 1, 0, 0, 0, 1'b1);
        push_cmd(OP_VELOCITY, 32'hFFFFFFF0, 32'sh20000, 32'sh10000, 32'sh8000, 1'b0);
        push_cmd(OP_TICK, 32'h20, 0, 0, 0, 1'b0);
        push_cmd(OP_ESTOP, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ESTOP, 1, 0, 0, 0, 1'b0);
        push_cmd(OP_ESTOP, 1, 0, 0, 0, 1'b1);
        push_cmd(OP_VELOCITY, 1, 32'sh1000, 0, 0, 1'b0);
        push_cmd(OP_TICK, 100, 0, 0, 0, 1'b0);
        drain();

        // random items, then wait until every frame is back before continuing
        random_phase(150);
        drain();

        write_reg(REG_GAIN, 65535);
        write_reg(REG_HALF_BASE, 20'hFFFFF);
        write_reg(REG_SMOOTH, 0);
        write_reg(REG_THRESHOLD, 0);
        random_phase(300);
        drain();

        write_reg(REG_GAIN, 1);
        write_reg(REG_HALF_BASE, 1);
        write_reg(REG_SMOOTH, 1);
        write_reg(REG_ACCEL, 0);
        write_reg(REG_DECEL, 65535);
        write_reg(REG_TIMEOUT, 0);
        write_reg(REG_THRESHOLD, 65535);
        random_phase(300);
        drain();

        write_reg(REG_GAIN, 3000);
        write_reg(REG_HALF_BASE, 50000);
        write_reg(REG_ACCEL, 65535);
        write_reg(REG_DECEL, 0);
        write_reg(REG_TIMEOUT, 65535);
        write_reg(REG_THRESHOLD, 10);
        random_phase(300);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_GAIN, $urandom_range(1, 65535));
            write_reg(REG_HALF_BASE, $urandom_range(1, 100000));
            write_reg(REG_SMOOTH, $urandom_range(0, 3) != 0);
            write_reg(REG_ACCEL, $urandom_range(0, 500));
            write_reg(REG_DECEL, $urandom_range(0, 500));
            write_reg(REG_TIMEOUT, $urandom_range(0, 600));
            write_reg(REG_THRESHOLD, $urandom_range(0, 200));
            random_phase(220);
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
